FILE: src/ddbcc_pkg.sv
package ddbcc_pkg;

   // operation codes of a request transaction
   localparam logic [2:0] OP_SET_NEXT       = 3'd0;
   localparam logic [2:0] OP_START          = 3'd1;
   localparam logic [2:0] OP_STOP           = 3'd2;
   localparam logic [2:0] OP_RX_IRQ         = 3'd3;
   localparam logic [2:0] OP_TX_IRQ         = 3'd4;
   localparam logic [2:0] OP_CLEAR_COMPLETE = 3'd5;
   localparam logic [2:0] OP_CLEAR_ERROR    = 3'd6;

   // start outcome codes
   localparam logic [1:0] START_OK          = 2'd0;
   localparam logic [1:0] START_BUSY        = 2'd1;
   localparam logic [1:0] START_SUBMIT_FAIL = 2'd2;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] buf_addr;
      logic [31:0] buf_len;
      logic        irq_complete;
      logic        irq_error;
      logic        irq_delay;
      logic        submit_fail;
   } req_payload_type;

   typedef struct packed {
      logic        running;
      logic        next_pending;
      logic        complete_flag;
      logic        rx_error_flag;
      logic        issue_valid;
      logic [31:0] issue_addr;
      logic [31:0] issue_len;
      logic        reset_engine;
      logic [31:0] returned_addr;
      logic [31:0] returned_len;
      logic [1:0]  start_result;
   } rsp_payload_type;

endpackage

FILE: src/dma_double_buffer_chunk_chainer.sv
// Receive-side double-buffer DMA chainer. Each request transaction carries one event
// (queue a next buffer, start, stop, rx or tx interrupt, flag clear) and produces
// exactly one response transaction with the status bits after the event, any transfer
// command issued (at most MAX_CHUNK bytes), the engine reset pulse, the displaced queued
// buffer and the start outcome. A request is taken into an input register, and its
// response is loaded from there into the output register once the output register is
// empty or not stalled. One request is accepted every cycle while the output is not
// stalled, because the whole state update is a single register-to-register pass (one
// chunk compare, one address add and one remaining-length subtract). The input stalls
// only while the output register is full and stalled.
module dma_double_buffer_chunk_chainer
   import ddbcc_pkg::*;
#(
   parameter int unsigned MAX_CHUNK = 65536
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   localparam logic [31:0] CHUNK_CAP = 32'(MAX_CHUNK);

   // input register
   logic            s1_vld_ff;
   req_payload_type s1_req_ff;

   // controller state
   logic [31:0] work_base_ff, work_base_in;
   logic [31:0] work_len_ff,  work_len_in;
   logic [31:0] next_base_ff, next_base_in;
   logic [31:0] next_len_ff,  next_len_in;
   logic [31:0] cur_addr_ff,  cur_addr_in;  // work_base + bytes already issued
   logic [31:0] remain_ff,    remain_in;    // bytes of working buffer not yet issued
   logic        armed_ff,     armed_in;
   logic        run_ff,       run_in;
   logic        next_ff,      next_in;
   logic        cmpl_ff,      cmpl_in;
   logic        rxerr_ff,     rxerr_in;

   // output register
   logic            rsp_vld_ff;
   rsp_payload_type rsp_ff, rsp_in;

   logic        advance;
   logic [31:0] chunk_src;
   logic [31:0] chunk_addr;
   logic [31:0] chunk_len;
   logic        chunk_go;

   assign advance   = s1_vld_ff & (~rsp_vld_ff | ~rsp_stall);
   assign req_stall = s1_vld_ff & ~advance;

   // input register load
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_vld_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         s1_req_ff <= req_payload;
      end
   end

   // chunk clip on the selected remaining length
   always_comb begin
      chunk_len = (chunk_src < CHUNK_CAP) ? chunk_src : CHUNK_CAP;
   end

   // event decode and next state
   always_comb begin
      work_base_in = work_base_ff;
      work_len_in  = work_len_ff;
      next_base_in = next_base_ff;
      next_len_in  = next_len_ff;
      cur_addr_in  = cur_addr_ff;
      remain_in    = remain_ff;
      armed_in     = armed_ff;
      run_in       = run_ff;
      next_in      = next_ff;
      cmpl_in      = cmpl_ff;
      rxerr_in     = rxerr_ff;
      chunk_src    = remain_ff;
      chunk_addr   = cur_addr_ff;
      chunk_go     = 1'b0;
      rsp_in       = '0;

      case (s1_req_ff.op)
         OP_SET_NEXT: begin
            rsp_in.returned_addr = next_base_ff;
            rsp_in.returned_len  = next_len_ff;
            next_base_in         = s1_req_ff.buf_addr;
            next_len_in          = s1_req_ff.buf_len;
            next_in              = 1'b1;
         end
         OP_START: begin
            if (next_ff && run_ff) begin
               rsp_in.start_result = START_BUSY;
            end else begin
               armed_in     = 1'b1;
               run_in       = 1'b1;
               next_in      = 1'b0;
               work_base_in = next_base_ff;
               work_len_in  = next_len_ff;
               chunk_src    = next_len_ff;
               chunk_addr   = next_base_ff;
               chunk_go     = 1'b1;
               if (s1_req_ff.submit_fail) begin
                  rsp_in.start_result = START_SUBMIT_FAIL;
               end
            end
         end
         OP_STOP: begin
            armed_in = 1'b0;
         end
         OP_RX_IRQ: begin
            if (s1_req_ff.irq_error) begin
               rxerr_in            = 1'b1;
               rsp_in.reset_engine = 1'b1;
            end else if (s1_req_ff.irq_complete) begin
               if (remain_ff == '0) begin
                  // end of working buffer
                  cmpl_in = 1'b1;
                  if (!armed_ff || !next_ff) begin
                     run_in      = 1'b0;
                     cur_addr_in = work_base_ff;
                     remain_in   = work_len_ff;
                  end else begin
                     next_in      = 1'b0;
                     work_base_in = next_base_ff;
                     work_len_in  = next_len_ff;
                     chunk_src    = next_len_ff;
                     chunk_addr   = next_base_ff;
                     chunk_go     = 1'b1;
                  end
               end else begin
                  chunk_go = 1'b1;
               end
               if (chunk_go && s1_req_ff.submit_fail) begin
                  rxerr_in = 1'b1;
               end
            end
         end
         OP_TX_IRQ: begin
            rsp_in.reset_engine = s1_req_ff.irq_error;
         end
         OP_CLEAR_COMPLETE: begin
            cmpl_in = 1'b0;
         end
         OP_CLEAR_ERROR: begin
            rxerr_in = 1'b0;
         end
         default: begin
         end
      endcase

      // issue a transfer and move the cursor past it
      if (chunk_go) begin
         rsp_in.issue_valid = 1'b1;
         rsp_in.issue_addr  = chunk_addr;
         rsp_in.issue_len   = chunk_len;
         cur_addr_in        = chunk_addr + chunk_len;
         remain_in          = chunk_src - chunk_len;
      end

      rsp_in.running       = run_in;
      rsp_in.next_pending  = next_in;
      rsp_in.complete_flag = cmpl_in;
      rsp_in.rx_error_flag = rxerr_in;
   end

   // state update
   always_ff @(posedge clock) begin
      if (reset) begin
         work_base_ff <= '0;
         work_len_ff  <= '0;
         next_base_ff <= '0;
         next_len_ff  <= '0;
         cur_addr_ff  <= '0;
         remain_ff    <= '0;
         armed_ff     <= 1'b0;
         run_ff       <= 1'b0;
         next_ff      <= 1'b0;
         cmpl_ff      <= 1'b0;
         rxerr_ff     <= 1'b0;
      end else if (advance) begin
         work_base_ff <= work_base_in;
         work_len_ff  <= work_len_in;
         next_base_ff <= next_base_in;
         next_len_ff  <= next_len_in;
         cur_addr_ff  <= cur_addr_in;
         remain_ff    <= remain_in;
         armed_ff     <= armed_in;
         run_ff       <= run_in;
         next_ff      <= next_in;
         cmpl_ff      <= cmpl_in;
         rxerr_ff     <= rxerr_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_vld_ff <= 1'b0;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_vld_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_chunk_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_ff.issue_valid) |-> (rsp_ff.issue_len <= CHUNK_CAP))
      else $error("issued transfer longer than chunk cap");

   a_remain_le_len: assert property (@(posedge clock) disable iff (reset)
      remain_ff <= work_len_ff)
      else $error("remaining bytes exceed working buffer length");

   a_advance_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_vld_ff)
      else $error("processed transaction produced no response");

   a_reset_no_issue: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_ff.reset_engine) |-> !rsp_ff.issue_valid)
      else $error("engine reset pulsed alongside a transfer issue");
`endif

endmodule

FILE: sim/dma_double_buffer_chunk_chainer_tb.sv
module dma_double_buffer_chunk_chainer_tb;
   import ddbcc_pkg::*;

   localparam logic [31:0] CHUNK_MAX      = 32'd65536;
   localparam logic [2:0]  OP_UNUSED      = 3'd7;
   localparam int          DIRECTED_ROWS  = 22;
   localparam int          RANDOM_ITEMS   = 700;
   localparam int          DRAIN_CYCLES   = 10;
   localparam int          WATCHDOG_LIMIT = 4000;
   localparam int          REPORT_LIMIT   = 10;

   logic            clock = 1'b0;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_payload;

   // responses still owed by the block, oldest first
   rsp_payload_type owed_responses[$];
   int              mismatches = 0;
   int              responses_seen = 0;
   int              idle_cycles = 0;
   int              quiet_items = 0;

   // predicted chainer state, reset values
   logic [31:0] wrk_base = '0;
   logic [31:0] wrk_len = '0;
   logic [31:0] nxt_base = '0;
   logic [31:0] nxt_len = '0;
   logic [31:0] issued_bytes = '0;
   logic        chain_armed = 1'b0;
   logic        run_bit = 1'b0;
   logic        next_bit = 1'b0;
   logic        complete_bit = 1'b0;
   logic        rxerr_bit = 1'b0;

   // directed stimulus table
   req_payload_type dir_req[DIRECTED_ROWS];
   rsp_payload_type dir_rsp[DIRECTED_ROWS];
   bit              dir_known[DIRECTED_ROWS];

   dma_double_buffer_chunk_chainer #(
      .MAX_CHUNK(CHUNK_MAX)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic req_payload_type make_req(input logic [2:0] op,
                                                input logic [31:0] addr,
                                                input logic [31:0] len,
                                                input logic comp, input logic err,
                                                input logic dly, input logic fail);
      req_payload_type r;
      r.op = op;
      r.buf_addr = addr;
      r.buf_len = len;
      r.irq_complete = comp;
      r.irq_error = err;
      r.irq_delay = dly;
      r.submit_fail = fail;
      return r;
   endfunction

   function automatic rsp_payload_type status_word(input logic run, input logic nxt,
                                                   input logic cmp, input logic err,
                                                   input logic iv, input logic [31:0] ia,
                                                   input logic [31:0] il, input logic rst,
                                                   input logic [31:0] ra,
                                                   input logic [31:0] rl,
                                                   input logic [1:0] sr);
      rsp_payload_type s;
      s.running = run;
      s.next_pending = nxt;
      s.complete_flag = cmp;
      s.rx_error_flag = err;
      s.issue_valid = iv;
      s.issue_addr = ia;
      s.issue_len = il;
      s.reset_engine = rst;
      s.returned_addr = ra;
      s.returned_len = rl;
      s.start_result = sr;
      return s;
   endfunction

   // buffer lengths that finish within a handful of chunks
   function automatic logic [31:0] short_buffer_len();
      case ($urandom_range(7))
         0: return 32'd0;
         1: return CHUNK_MAX;
         2: return 2 * CHUNK_MAX;
         3: return $urandom_range(1, 16);
         default: return $urandom_range(1, 3 * 65536 + 100);
      endcase
   endfunction

   // advance the chainer state by one event and form its response
   task automatic predict_response(input req_payload_type r, output rsp_payload_type e);
      logic [31:0] remaining;
      logic [31:0] seg;
      logic        fresh;
      e = '0;
      case (r.op)
         OP_SET_NEXT: begin
            e.returned_addr = nxt_base;
            e.returned_len = nxt_len;
            nxt_base = r.buf_addr;
            nxt_len = r.buf_len;
            next_bit = 1'b1;
         end
         OP_START: begin
            if (next_bit && run_bit) begin
               e.start_result = START_BUSY;
            end else begin
               // takes the queued buffer; with the queue empty, the last queued buffer is taken again
               chain_armed = 1'b1;
               run_bit = 1'b1;
               next_bit = 1'b0;
               wrk_base = nxt_base;
               wrk_len = nxt_len;
               issued_bytes = (wrk_len < CHUNK_MAX) ? wrk_len : CHUNK_MAX;
               e.issue_valid = 1'b1;
               e.issue_addr = wrk_base;
               e.issue_len = issued_bytes;
               if (r.submit_fail) e.start_result = START_SUBMIT_FAIL;
            end
         end
         OP_STOP: chain_armed = 1'b0;
         OP_RX_IRQ: begin
            // error beats completion; delay alone is ignored
            if (r.irq_error) begin
               rxerr_bit = 1'b1;
               e.reset_engine = 1'b1;
            end else if (r.irq_complete) begin
               fresh = 1'b1;
               if (issued_bytes >= wrk_len) begin
                  issued_bytes = '0;
                  complete_bit = 1'b1;
                  if (!chain_armed || !next_bit) begin
                     run_bit = 1'b0;
                     fresh = 1'b0;
                  end else begin
                     next_bit = 1'b0;
                     wrk_base = nxt_base;
                     wrk_len = nxt_len;
                  end
               end
               if (fresh) begin
                  remaining = wrk_len - issued_bytes;
                  seg = (remaining < CHUNK_MAX) ? remaining : CHUNK_MAX;
                  e.issue_valid = 1'b1;
                  e.issue_addr = wrk_base + issued_bytes;
                  e.issue_len = seg;
                  if (r.submit_fail) rxerr_bit = 1'b1;
                  issued_bytes = issued_bytes + seg;
               end
            end
         end
         OP_TX_IRQ: begin
            if (r.irq_error) e.reset_engine = 1'b1;
         end
         OP_CLEAR_COMPLETE: complete_bit = 1'b0;
         OP_CLEAR_ERROR: rxerr_bit = 1'b0;
         default: ;
      endcase
      e.running = run_bit;
      e.next_pending = next_bit;
      e.complete_flag = complete_bit;
      e.rx_error_flag = rxerr_bit;
   endtask

   // present one request transaction after a random gap, then record its response
   task automatic send_item(input req_payload_type r, input bit known,
                            input rsp_payload_type typed);
      int              k;
      int              gap;
      bit              stalled;
      rsp_payload_type predicted;
      k = $urandom_range(99);
      if (quiet_items > 0) begin
         gap = 0;
         quiet_items--;
      end else if (k < 3) begin
         gap = 0;
         quiet_items = $urandom_range(20, 50);
      end else if (k < 55) begin
         gap = 0;
      end else if (k < 88) begin
         gap = $urandom_range(1, 3);
      end else if (k < 97) begin
         gap = $urandom_range(4, 12);
      end else begin
         gap = $urandom_range(20, 60);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      // stall is stable by the falling edge
      do begin
         @(negedge clock);
         stalled = (req_stall !== 1'b0);
         @(posedge clock);
      end while (stalled);
      predict_response(r, predicted);
      owed_responses.push_back(known ? typed : predicted);
   endtask

   // stimulus
   initial begin : stimulus
      req_payload_type r;
      int              n;
      int              pick;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;

      dir_known = '{default: 1'b0};
      dir_rsp = '{default: '0};
      // unused op after reset, every field high
      dir_req[0] = make_req(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1);
      dir_rsp[0] = status_word(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0,
                               32'h0, 32'h0, START_OK);
      // start on the empty reset buffer: zero-length transfer
      dir_req[1] = make_req(OP_START, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0);
      dir_rsp[1] = status_word(1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 32'h0, 32'h0, 1'b0,
                               32'h0, 32'h0, START_OK);
      dir_req[2] = make_req(OP_RX_IRQ, 0, 0, 1'b1, 1'b0, 1'b0, 1'b0);
      dir_rsp[2] = status_word(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0,
                               32'h0, 32'h0, START_OK);
      // refused start still takes the buffer
      dir_req[3] = make_req(OP_START, 0, 0, 1'b0, 1'b0, 1'b0, 1'b1);
      dir_rsp[3] = status_word(1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 32'h0, 32'h0, 1'b0,
                               32'h0, 32'h0, START_SUBMIT_FAIL);
      dir_req[4] = make_req(OP_SET_NEXT, 32'hFFFF_FFF0, 32'hFFFF_FFFF,
                            1'b0, 1'b0, 1'b0, 1'b0);
      dir_rsp[4] = status_word(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0,
                               32'h0, 32'h0, START_OK);
      // busy: queued buffer while running
      dir_req[5] = make_req(OP_START, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0);
      dir_rsp[5] = status_word(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0,
                               32'h0, 32'h0, START_BUSY);
      // error and completion together: error wins
      dir_req[6] = make_req(OP_RX_IRQ, 0, 0, 1'b1, 1'b1, 1'b0, 1'b0);
      dir_rsp[6] = status_word(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 32'h0, 32'h0, 1'b1,
                               32'h0, 32'h0, START_OK);
      dir_req[7] = make_req(OP_TX_IRQ, 0, 0, 1'b0, 1'b1, 1'b0, 1'b0);
      dir_req[8] = make_req(OP_TX_IRQ, 0, 0, 1'b1, 1'b0, 1'b1, 1'b0);
      dir_req[9] = make_req(OP_CLEAR_ERROR, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0);
      dir_req[10] = make_req(OP_CLEAR_COMPLETE, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0);
      // displaces the maximal buffer; base near the top so the address wraps
      dir_req[11] = make_req(OP_SET_NEXT, 32'hFFFF_F000, 32'h0001_0001,
                             1'b0, 1'b0, 1'b0, 1'b0);
      dir_rsp[11] = status_word(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0,
                                32'hFFFF_FFF0, 32'hFFFF_FFFF, START_OK);
      dir_req[12] = make_req(OP_RX_IRQ, 0, 0, 1'b1, 1'b0, 1'b0, 1'b0);
      dir_req[13] = make_req(OP_RX_IRQ, 0, 0, 1'b1, 1'b0, 1'b0, 1'b1);
      dir_req[14] = make_req(OP_RX_IRQ, 0, 0, 1'b0, 1'b0, 1'b1, 1'b0);
      dir_req[15] = make_req(OP_RX_IRQ, 0, 0, 1'b0, 1'b0, 1'b0, 1'b1);
      dir_req[16] = make_req(OP_STOP, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0);
      dir_req[17] = make_req(OP_RX_IRQ, 0, 0, 1'b1, 1'b0, 1'b0, 1'b0);
      dir_req[18] = make_req(OP_START, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0);
      dir_req[19] = make_req(OP_CLEAR_ERROR, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0);
      dir_req[20] = make_req(OP_SET_NEXT, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0);
      dir_req[21] = make_req(OP_START, 0, 0, 1'b1, 1'b1, 1'b1, 1'b1);
      foreach (dir_rsp[i]) begin
         if (i <= 6 || i == 11) dir_known[i] = 1'b1;
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < DIRECTED_ROWS; n++) begin
         send_item(dir_req[n], dir_known[n], dir_rsp[n]);
      end

      // random part: mostly buffer chains driven by rx completions
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(99);
         r = make_req(OP_RX_IRQ, $urandom, $urandom, 1'b1, 1'b0,
                      $urandom_range(1) != 0, $urandom_range(9) == 0);
         if (pick < 40) begin
            // plain completion
         end else if (pick < 46) begin
            r.irq_error = 1'b1;
            r.irq_complete = $urandom_range(1) != 0;
         end else if (pick < 50) begin
            r.irq_complete = 1'b0;
         end else if (pick < 63) begin
            r.op = OP_SET_NEXT;
            if ($urandom_range(7) == 0) begin
               // full-range random length only ever queued, then displaced at once
               send_item(r, 1'b0, '0);
               r.buf_addr = $urandom;
            end
            r.buf_len = short_buffer_len();
         end else if (pick < 75) begin
            r.op = OP_START;
         end else if (pick < 80) begin
            r.op = OP_STOP;
         end else if (pick < 86) begin
            r.op = OP_TX_IRQ;
            r.irq_error = $urandom_range(1) != 0;
         end else if (pick < 91) begin
            r.op = OP_CLEAR_COMPLETE;
         end else if (pick < 96) begin
            r.op = OP_CLEAR_ERROR;
         end else begin
            r.op = OP_UNUSED;
         end
         send_item(r, 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (owed_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // result side back-pressure: runs of stall and free flow
   initial begin : result_stall
      int k;
      int span;
      forever begin
         k = $urandom_range(99);
         if (k < 70) begin
            rsp_stall <= 1'b0;
            span = (k < 60) ? $urandom_range(1, 8) : $urandom_range(30, 80);
         end else begin
            rsp_stall <= 1'b1;
            span = (k < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
         end
         repeat (span) @(posedge clock);
      end
   end

   // compare each response transaction with the oldest owed one
   always @(posedge clock) begin : response_check
      rsp_payload_type want;
      string           wrong;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         responses_seen++;
         if (owed_responses.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("response %0d arrived with none owed: %h", responses_seen,
                        rsp_payload);
         end else begin
            want = owed_responses.pop_front();
            wrong = "";
            if (rsp_payload.running !== want.running) wrong = {wrong, " running"};
            if (rsp_payload.next_pending !== want.next_pending)
               wrong = {wrong, " next_pending"};
            if (rsp_payload.complete_flag !== want.complete_flag)
               wrong = {wrong, " complete_flag"};
            if (rsp_payload.rx_error_flag !== want.rx_error_flag)
               wrong = {wrong, " rx_error_flag"};
            if (rsp_payload.issue_valid !== want.issue_valid) wrong = {wrong, " issue_valid"};
            if (rsp_payload.issue_addr !== want.issue_addr) wrong = {wrong, " issue_addr"};
            if (rsp_payload.issue_len !== want.issue_len) wrong = {wrong, " issue_len"};
            if (rsp_payload.reset_engine !== want.reset_engine)
               wrong = {wrong, " reset_engine"};
            if (rsp_payload.returned_addr !== want.returned_addr)
               wrong = {wrong, " returned_addr"};
            if (rsp_payload.returned_len !== want.returned_len)
               wrong = {wrong, " returned_len"};
            if (rsp_payload.start_result !== want.start_result)
               wrong = {wrong, " start_result"};
            if (wrong != "") begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("response %0d mismatch in%s: expected %h, got %h",
                           responses_seen, wrong, want, rsp_payload);
            end
         end
      end
   end

   // watchdog: cycles with no transaction on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

endmodule

FILE: filelist.f
src/ddbcc_pkg.sv
src/dma_double_buffer_chunk_chainer.sv
sim/dma_double_buffer_chunk_chainer_tb.sv
